// ===== rtl/core/ppi_pkg.sv =====
// ppi_pkg: shared types and constants for the particle pool integrator.
// No dependencies.
package ppi_pkg;

  typedef enum logic [1:0] {
    CMD_SPAWN = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK_RD,
    ST_TICK_A,
    ST_TICK_B,
    ST_TICK_C,
    ST_TICK_D,
    ST_TICK_WR,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_READ_RD,
    ST_READ_OUT,
    ST_OUT
  } state_t;

  // one pool entry
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic        [23:0] speed;
    logic signed [23:0] accel;
    logic        [31:0] birth;
    logic signed [23:0] life;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;     // latch input word
    logic spawn_wr;    // write spawn entry at slot count
    logic tick_start;  // advance clock, clear walk index
    logic rd;          // read entry at walk index (or read index)
    logic rd_sel_idx;  // 1: read address from input index
    logic step_a;      // stage: inner, speed delta
    logic step_b;      // stage: travel
    logic step_c;      // stage: dir products, position sums
    logic step_d;      // stage: saturate positions, clamp speed, age check
    logic upd_wr;      // write updated entry, advance or kill
    logic mv_rd;       // read last entry
    logic mv_wr;       // write moved entry to walk index
    logic clear;       // empty pool
    logic res_load;    // build result
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_done;   // walk index reached count
    logic full;        // pool full
    logic dead;        // current particle expired
    logic last;        // current slot is the last live one
  } sts_t;

endpackage

// ===== rtl/core/particle_pool_integrator_core.sv =====
// particle_pool_integrator_core: top level, sequencer plus datapath.
// Depends on ppi_pkg, ppi_ctrl, ppi_dp.
//
//   channel   handshake               payload
//   input     in_valid / in_ready     cmd, index, pos_*, dir_*, speed, accel, lifetime, delta_time
//   output    out_valid / out_ready   live_count, overflow, hit, out_*, out_speed, out_age
//
// Spawn and clear go straight to the result state; read first reads the slot. A tick walks each
// live particle through read, stages A to D and write-back; the last entry fills a dead slot.
// One word is in work at a time; a held result blocks the next word.
// Synchronous reset empties the pool and zeroes the clock.
module particle_pool_integrator_core #(
  parameter int POOL_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic [5:0]         index,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  input  logic [23:0]        speed,
  input  logic signed [23:0] accel,
  input  logic signed [23:0] lifetime,
  input  logic [23:0]        delta_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [6:0]         live_count,
  output logic               overflow,
  output logic               hit,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [23:0]        out_speed,
  output logic [23:0]        out_age
);
  import ppi_pkg::*;

  ctl_t ctl;
  sts_t sts;

  ppi_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_cmd(cmd), .in_ready,
    .out_valid, .out_ready, .sts, .ctl
  );

  ppi_dp #(.POOL_DEPTH(POOL_DEPTH)) u_dp (
    .clk, .rst, .ctl, .sts, .cmd, .index, .pos_x, .pos_y, .pos_z,
    .dir_x, .dir_y, .dir_z, .speed, .accel, .lifetime, .delta_time,
    .live_count, .overflow, .hit, .out_x, .out_y, .out_z, .out_speed, .out_age
  );

endmodule

// ===== rtl/core/ppi_ctrl.sv =====
// ppi_ctrl: command sequencer for the particle pool integrator.
// Depends on ppi_pkg.
module ppi_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     in_cmd,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  ppi_pkg::sts_t  sts,
  output ppi_pkg::ctl_t  ctl
);
  import ppi_pkg::*;

  state_t state, state_next;
  logic   oval, oval_next;
  logic   acc;
  cmd_t   cur, cur_next;

  assign in_ready  = (state == ST_IDLE) && !oval;
  assign out_valid = oval;
  assign acc       = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      oval  <= 1'b0;
      cur   <= CMD_SPAWN;
    end else begin
      state <= state_next;
      oval  <= oval_next;
      cur   <= cur_next;
    end
  end

  always_comb begin
    state_next = state;
    cur_next   = cur;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          cur_next = cmd_t'(in_cmd);
          unique case (cmd_t'(in_cmd))
            CMD_TICK:  state_next = ST_TICK_RD;
            CMD_READ:  state_next = ST_READ_RD;
            default:   state_next = ST_OUT;
          endcase
        end
      end
      ST_TICK_RD:  state_next = sts.walk_done ? ST_OUT : ST_TICK_A;
      ST_TICK_A:   state_next = ST_TICK_B;
      ST_TICK_B:   state_next = ST_TICK_C;
      ST_TICK_C:   state_next = ST_TICK_D;
      ST_TICK_D:   state_next = ST_TICK_WR;
      ST_TICK_WR: begin
        if (sts.dead && !sts.last) state_next = ST_MOVE_RD;
        else if (sts.dead)         state_next = ST_OUT;
        else                       state_next = ST_TICK_RD;
      end
      ST_MOVE_RD:  state_next = ST_MOVE_WR;
      ST_MOVE_WR:  state_next = ST_TICK_RD;
      ST_READ_RD:  state_next = ST_READ_OUT;
      ST_READ_OUT: state_next = ST_OUT;
      ST_OUT:      state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    oval_next = oval;
    if (oval && out_ready) oval_next = 1'b0;
    if (state == ST_OUT)   oval_next = 1'b1;
  end

  always_comb begin
    ctl = '0;
    unique case (state)
      ST_IDLE: begin
        ctl.load_in = acc;
        if (acc && cmd_t'(in_cmd) == CMD_TICK) ctl.tick_start = 1'b1;
      end
      ST_TICK_RD: ctl.rd = !sts.walk_done;
      ST_TICK_A:  ctl.step_a = 1'b1;
      ST_TICK_B:  ctl.step_b = 1'b1;
      ST_TICK_C:  ctl.step_c = 1'b1;
      ST_TICK_D:  ctl.step_d = 1'b1;
      ST_TICK_WR: ctl.upd_wr = 1'b1;
      ST_MOVE_RD: ctl.mv_rd = 1'b1;
      ST_MOVE_WR: ctl.mv_wr = 1'b1;
      ST_READ_RD: begin
        ctl.rd         = 1'b1;
        ctl.rd_sel_idx = 1'b1;
      end
      ST_READ_OUT: ;
      ST_OUT: begin
        ctl.res_load = 1'b1;
        ctl.spawn_wr = (cur == CMD_SPAWN) && !sts.full;
        ctl.clear    = (cur == CMD_CLEAR);
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/ppi_dp.sv =====
// ppi_dp: pool memory, integrator arithmetic and result registers.
// Depends on ppi_pkg.
module ppi_dp #(
  parameter int POOL_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  ppi_pkg::ctl_t       ctl,
  output ppi_pkg::sts_t       sts,
  input  logic [1:0]          cmd,
  input  logic [5:0]          index,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  input  logic signed [15:0]  dir_x,
  input  logic signed [15:0]  dir_y,
  input  logic signed [15:0]  dir_z,
  input  logic [23:0]         speed,
  input  logic signed [23:0]  accel,
  input  logic signed [23:0]  lifetime,
  input  logic [23:0]         delta_time,
  output logic [6:0]          live_count,
  output logic                overflow,
  output logic                hit,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  output logic [23:0]         out_speed,
  output logic [23:0]         out_age
);
  import ppi_pkg::*;

  localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW = $clog2(POOL_DEPTH + 1);

  entry_t mem [POOL_DEPTH];
  entry_t rdat;
  entry_t cur;
  entry_t in_ent;

  logic [CW-1:0] count;
  logic [CW-1:0] walk;
  logic [31:0]   clock_now;
  logic [1:0]    in_cmd;
  logic [5:0]    in_idx;
  logic [23:0]   dt;
  logic          idx_ok;

  logic signed [43:0] inner;
  logic signed [37:0] dv;
  logic signed [44:0] travel;
  logic signed [60:0] px, py, pz;
  logic               dead_r;
  logic               rd_hit;

  logic [AW-1:0] wr_addr, rd_addr;
  logic          wr_en;
  entry_t        wr_data;

  // input latch
  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      in_cmd <= cmd;
      in_idx <= index;
      dt     <= delta_time;
      in_ent <= '{pos_x: pos_x, pos_y: pos_y, pos_z: pos_z,
                  dir_x: dir_x, dir_y: dir_y, dir_z: dir_z,
                  speed: speed, accel: accel, birth: clock_now,
                  life: lifetime};
    end
  end

  assign idx_ok = (32'(in_idx) < 32'(count)) && (32'(in_idx) < 32'(POOL_DEPTH));

  // memory port
  always_comb begin
    rd_addr = ctl.rd_sel_idx ? AW'(in_idx) : (ctl.mv_rd ? AW'(count) : AW'(walk));
    wr_en   = 1'b0;
    wr_addr = AW'(walk);
    wr_data = cur;
    if (ctl.spawn_wr) begin
      wr_en   = 1'b1;
      wr_addr = AW'(count);
      wr_data = in_ent;
    end else if (ctl.upd_wr) begin
      wr_en = 1'b1;
    end else if (ctl.mv_wr) begin
      wr_en   = 1'b1;
      wr_data = rdat;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (ctl.rd || ctl.mv_rd) rdat <= mem[rd_addr];
  end

  function automatic logic signed [63:0] rnd(input logic signed [63:0] x, input int n);
    logic signed [63:0] y;
    y = x + (64'sd1 <<< (n - 1));
    return y >>> n;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [60:0] x);
    if (x > 61'sd2147483647)   return 32'sh7FFFFFFF;
    if (x < -61'sd2147483648)  return 32'sh80000000;
    return x[31:0];
  endfunction

  logic signed [63:0] t_in, t_dv, t_ds, t_px, t_py, t_pz;
  logic signed [60:0] spd_n;
  logic [31:0]        age;

  // first stage works on the freshly read entry, later stages on the latched copy cur
  always_comb begin
    t_in  = rnd(($signed({40'd0, rdat.speed}) <<< 17)
                + $signed({40'd0, dt}) * 64'(rdat.accel), 17);
    t_dv  = rnd(64'(rdat.accel) * $signed({40'd0, dt}), 16);
    t_ds  = rnd($signed({40'd0, dt}) * 64'(inner), 12);
    t_px  = rnd(64'(cur.dir_x) * 64'(travel), 14);
    t_py  = rnd(64'(cur.dir_y) * 64'(travel), 14);
    t_pz  = rnd(64'(cur.dir_z) * 64'(travel), 14);
    spd_n = $signed({37'd0, cur.speed}) + 61'(dv);
    age   = clock_now - cur.birth;
  end

  // walk index, live count and clock
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      clock_now <= '0;
      walk      <= '0;
    end else begin
      if (ctl.tick_start) begin
        clock_now <= clock_now + 32'(delta_time);
        walk      <= '0;
      end
      if (ctl.spawn_wr) count <= count + 1'b1;
      if (ctl.clear)    count <= '0;
      if (ctl.upd_wr) begin
        if (dead_r) count <= count - 1'b1;
        else        walk  <= walk + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step_a) begin
      cur   <= rdat;
      inner <= 44'(t_in);
      dv    <= 38'(t_dv);
    end else begin
      if (ctl.step_b) travel <= 45'(t_ds);
      if (ctl.step_c) begin
        px <= 61'(cur.pos_x) + 61'(t_px);
        py <= 61'(cur.pos_y) + 61'(t_py);
        pz <= 61'(cur.pos_z) + 61'(t_pz);
      end
      if (ctl.step_d) begin
        cur.pos_x <= sat32(px);
        cur.pos_y <= sat32(py);
        cur.pos_z <= sat32(pz);
        if (spd_n < 0)                  cur.speed <= '0;
        else if (spd_n > 61'sd16777215) cur.speed <= 24'hFFFFFF;
        else                            cur.speed <= spd_n[23:0];
        dead_r <= (cur.life <= 0) || ($signed({1'b0, age}) >= 33'(cur.life));
      end
    end
  end

  assign sts.walk_done = (walk >= count);
  assign sts.full      = (32'(count) >= 32'(POOL_DEPTH));
  assign sts.dead      = dead_r;
  assign sts.last      = (walk == count - 1'b1);

  // result
  logic [31:0] rage;
  assign rage = clock_now - rdat.birth;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_hit <= 1'b0;
    end else if (ctl.rd_sel_idx) begin
      rd_hit <= idx_ok;
    end
  end

  logic [CW-1:0] cnt_after;
  always_comb begin
    cnt_after = count;
    if (ctl.spawn_wr) cnt_after = count + 1'b1;
    if (ctl.clear)    cnt_after = '0;
  end

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      live_count <= 7'(cnt_after);
      overflow   <= (in_cmd == CMD_SPAWN) && sts.full;
      hit        <= 1'b0;
      out_x      <= '0;
      out_y      <= '0;
      out_z      <= '0;
      out_speed  <= '0;
      out_age    <= '0;
      if (in_cmd == CMD_READ && rd_hit) begin
        hit       <= 1'b1;
        out_x     <= rdat.pos_x;
        out_y     <= rdat.pos_y;
        out_z     <= rdat.pos_z;
        out_speed <= rdat.speed;
        out_age   <= (rage > 32'hFFFFFF) ? 24'hFFFFFF : rage[23:0];
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for particle_pool_integrator_core.
// Depends on ppi_pkg and the core RTL; runs directed rows, then random words,
// and checks every result word against a local model of the pool.
`timescale 1ns / 100ps

module tb_top;
  import ppi_pkg::*;

  typedef struct {
    cmd_t               cmd;
    logic [5:0]         index;
    logic signed [31:0] px, py, pz;
    logic signed [15:0] dx, dy, dz;
    logic [23:0]        spd;
    logic signed [23:0] acc, life;
    logic [23:0]        dt;
    bit                 chk;
    logic [6:0]         e_live;
    bit                 e_ovf, e_hit;
  } word_t;

  typedef struct packed {
    logic [6:0]         live;
    logic               ovf, hit;
    logic signed [31:0] x, y, z;
    logic [23:0]        spd, age;
  } res_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] cmd;
  logic [5:0] index;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [15:0] dir_x, dir_y, dir_z;
  logic [23:0] speed, delta_time;
  logic signed [23:0] accel, lifetime;
  logic [6:0] live_count;
  logic overflow, hit;
  logic signed [31:0] out_x, out_y, out_z;
  logic [23:0] out_speed, out_age;

  particle_pool_integrator_core uut (.*);

  // pool model
  longint pool_px[64], pool_py[64], pool_pz[64];
  longint pool_dx[64], pool_dy[64], pool_dz[64];
  longint pool_spd[64], pool_acc[64], pool_life[64];
  logic [31:0] pool_birth[64];
  int unsigned pool_count;
  logic [31:0] pool_clock;

  res_t results_due[$];
  int errors;
  int shown;
  bit hold_req;
  bit quiet;

  function automatic longint rnd(longint x, int n);
    return (x + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic void move_slot(int d, int s);
    pool_px[d] = pool_px[s]; pool_py[d] = pool_py[s]; pool_pz[d] = pool_pz[s];
    pool_dx[d] = pool_dx[s]; pool_dy[d] = pool_dy[s]; pool_dz[d] = pool_dz[s];
    pool_spd[d] = pool_spd[s]; pool_acc[d] = pool_acc[s];
    pool_life[d] = pool_life[s]; pool_birth[d] = pool_birth[s];
  endfunction

  function automatic void integrate(logic [23:0] dt);
    int i;
    longint sdt, v, a, inner, travel;
    logic [31:0] age;
    bit dead;
    i = 0;
    sdt = longint'({40'b0, dt});
    pool_clock = pool_clock + {8'b0, dt};
    while (i < pool_count) begin
      v = pool_spd[i];
      a = pool_acc[i];
      inner = rnd(v * (64'sd1 <<< 17) + sdt * a, 17);
      travel = rnd(sdt * inner, 12);
      pool_px[i] = sat32(pool_px[i] + rnd(pool_dx[i] * travel, 14));
      pool_py[i] = sat32(pool_py[i] + rnd(pool_dy[i] * travel, 14));
      pool_pz[i] = sat32(pool_pz[i] + rnd(pool_dz[i] * travel, 14));
      v = v + rnd(a * sdt, 16);
      if (v < 0) v = 0;
      if (v > 64'hFFFFFF) v = 64'hFFFFFF;
      pool_spd[i] = v;
      age = pool_clock - pool_birth[i];
      dead = (pool_life[i] <= 0) || (longint'({32'b0, age}) >= pool_life[i]);
      if (dead) begin
        pool_count--;
        if (i == pool_count) break;
        move_slot(i, pool_count);
      end else begin
        i++;
      end
    end
  endfunction

  function automatic res_t apply_word(word_t w);
    res_t r;
    logic [31:0] age;
    r = '{default: '0};
    case (w.cmd)
      CMD_SPAWN: begin
        if (pool_count >= 64) begin
          r.ovf = 1'b1;
        end else begin
          pool_px[pool_count] = w.px; pool_py[pool_count] = w.py;
          pool_pz[pool_count] = w.pz;
          pool_dx[pool_count] = w.dx; pool_dy[pool_count] = w.dy;
          pool_dz[pool_count] = w.dz;
          pool_spd[pool_count] = longint'({40'b0, w.spd});
          pool_acc[pool_count] = w.acc;
          pool_life[pool_count] = w.life;
          pool_birth[pool_count] = pool_clock;
          pool_count++;
        end
      end
      CMD_TICK: integrate(w.dt);
      CMD_CLEAR: pool_count = 0;
      default: begin
        if (w.index < pool_count) begin
          age = pool_clock - pool_birth[w.index];
          r.hit = 1'b1;
          r.x = pool_px[w.index][31:0];
          r.y = pool_py[w.index][31:0];
          r.z = pool_pz[w.index][31:0];
          r.spd = pool_spd[w.index][23:0];
          r.age = (age > 32'hFFFFFF) ? 24'hFFFFFF : age[23:0];
        end
      end
    endcase
    r.live = pool_count[6:0];
    if (w.chk) begin
      r.live = w.e_live;
      r.ovf = w.e_ovf;
      r.hit = w.e_hit;
    end
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("[particle_pool_integrator_core] ERROR");
    $finish;
  end

  task automatic put_word(word_t w);
    bit taken;
    cmd <= w.cmd; index <= w.index;
    pos_x <= w.px; pos_y <= w.py; pos_z <= w.pz;
    dir_x <= w.dx; dir_y <= w.dy; dir_z <= w.dz;
    speed <= w.spd; accel <= w.acc; lifetime <= w.life; delta_time <= w.dt;
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    results_due.push_back(apply_word(w));
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  function automatic word_t mk(cmd_t c);
    word_t w;
    w = '{cmd: c, default: '0};
    return w;
  endfunction

  function automatic word_t rand_word(int spawn_pct);
    word_t w;
    int k;
    w = mk(CMD_READ);
    k = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) begin
      // noise: any bit pattern in every field
      w.cmd = cmd_t'($urandom_range(0, 3));
      if (w.cmd == CMD_CLEAR && $urandom_range(0, 3) != 0) w.cmd = CMD_READ;
      w.index = 6'($urandom); w.px = $urandom; w.py = $urandom; w.pz = $urandom;
      w.dx = 16'($urandom); w.dy = 16'($urandom); w.dz = 16'($urandom);
      w.spd = 24'($urandom); w.acc = 24'($urandom); w.life = 24'($urandom);
      w.dt = 24'($urandom);
    end else if (k < spawn_pct) begin
      w.cmd = CMD_SPAWN;
      w.px = $urandom_range(0, 32'h00FFFFFF) - 32'h00800000;
      w.py = $urandom_range(0, 32'h00FFFFFF) - 32'h00800000;
      w.pz = $urandom;
      w.dx = 16'($urandom_range(0, 32768) - 16384);
      w.dy = 16'($urandom_range(0, 32768) - 16384);
      w.dz = 16'($urandom_range(0, 32768) - 16384);
      w.spd = 24'($urandom_range(0, 24'h0FFFFF));
      w.acc = 24'($urandom_range(0, 24'h3FFFF) - 24'h20000);
      w.life = 24'($urandom_range(0, 24'h60000));
      if ($urandom_range(0, 15) == 0) w.life = 24'(-$urandom_range(0, 1000));
    end else if (k < spawn_pct + 12) begin
      w.cmd = CMD_TICK;
      w.dt = 24'($urandom_range(0, 24'h8000));
      if ($urandom_range(0, 15) == 0) w.dt = 24'($urandom);
    end else if (k < spawn_pct + 14) begin
      w.cmd = CMD_CLEAR;
    end else begin
      w.index = 6'($urandom_range(0, 63));
    end
    return w;
  endfunction

  // result side
  initial begin
    res_t e, a;
    bit take;
    int stall;
    int hold;
    out_ready = 1'b0;
    stall = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      take = out_valid && out_ready;
      a.live = live_count; a.ovf = overflow; a.hit = hit;
      a.x = out_x; a.y = out_y; a.z = out_z; a.spd = out_speed; a.age = out_age;
      @(posedge clk);
      if (take) begin
        if (results_due.size() == 0) begin
          errors++;
          if (shown < 10) begin
            shown++;
            $display("unexpected result word: live %0d", a.live);
          end
        end else begin
          e = results_due.pop_front();
          if (a != e) begin
            errors++;
            if (shown < 10) begin
              shown++;
              $display("mismatch exp live %0d ovf %0b hit %0b x %h y %h z %h spd %h age %h",
                       e.live, e.ovf, e.hit, e.x, e.y, e.z, e.spd, e.age);
              $display("         got live %0d ovf %0b hit %0b x %h y %h z %h spd %h age %h",
                       a.live, a.ovf, a.hit, a.x, a.y, a.z, a.spd, a.age);
            end
          end
        end
      end
      if (hold_req && hold == 0) hold = 600;
      if (hold > 0) begin
        hold--;
        if (hold == 0) hold_req = 1'b0;
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    word_t rows[$];
    word_t w;
    int n;
    errors = 0; shown = 0; hold_req = 1'b0; quiet = 1'b0;
    pool_count = 0; pool_clock = '0;
    rst = 1'b1; in_valid = 1'b0;
    cmd = '0; index = '0; pos_x = '0; pos_y = '0; pos_z = '0;
    dir_x = '0; dir_y = '0; dir_z = '0; speed = '0; accel = '0;
    lifetime = '0; delta_time = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    w = mk(CMD_READ); w.index = 0; w.chk = 1; rows.push_back(w);
    w = mk(CMD_TICK); w.dt = 24'hFFFFFF; w.chk = 1; rows.push_back(w);
    w = mk(CMD_SPAWN); w.px = 32'h7FFFFFFF; w.py = 32'h80000000; w.pz = 0;
    w.dx = 16384; w.dy = -16384; w.dz = 0; w.spd = 24'hFFFFFF; w.acc = 24'h7FFFFF;
    w.life = 24'h7FFFFF; w.chk = 1; w.e_live = 1; rows.push_back(w);
    w = mk(CMD_SPAWN); w.px = 32'h80000000; w.py = 32'h7FFFFFFF; w.pz = 32'hFFFF0000;
    w.dx = 16'h7FFF; w.dy = 16'h8000; w.dz = 16'hFFFF; w.spd = 0; w.acc = 24'h800000;
    w.life = 24'h7FFFFF; w.chk = 1; w.e_live = 2; rows.push_back(w);
    w = mk(CMD_SPAWN); w.spd = 24'h001000; w.dx = 16384; w.life = 0;
    w.chk = 1; w.e_live = 3; rows.push_back(w);
    w = mk(CMD_SPAWN); w.spd = 24'h002000; w.dy = 16384; w.life = 24'h800000;
    rows.push_back(w);
    w = mk(CMD_SPAWN); w.spd = 24'h004000; w.dz = -16384; w.acc = 24'hFFF000;
    w.life = 24'h020000; rows.push_back(w);
    for (int i = 0; i < 5; i++) begin
      w = mk(CMD_READ); w.index = 6'(i); rows.push_back(w);
    end
    w = mk(CMD_READ); w.index = 63; w.chk = 1; w.e_live = 5; rows.push_back(w);
    w = mk(CMD_TICK); w.dt = 24'h008000; rows.push_back(w);
    for (int i = 0; i < 4; i++) begin
      w = mk(CMD_READ); w.index = 6'(i); rows.push_back(w);
    end
    w = mk(CMD_TICK); w.dt = 24'hFFFFFF; rows.push_back(w);
    w = mk(CMD_READ); w.index = 0; rows.push_back(w);
    w = mk(CMD_READ); w.index = 1; rows.push_back(w);
    w = mk(CMD_CLEAR); w.chk = 1; rows.push_back(w);
    w = mk(CMD_READ); w.index = 0; w.chk = 1; rows.push_back(w);
    foreach (rows[i]) put_word(rows[i]);

    // random traffic, phases lean toward spawns to fill the pool
    for (n = 0; n < 1300; n++) begin
      if (n == 300) begin
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++) put_word(rand_word(50));
      end
      if (n == 600) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0) @(posedge clk);
      end
      if (n == 1150) quiet = 1'b1;
      put_word(rand_word(((n / 100) % 3 == 0) ? 85 : 45));
    end
    in_valid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0) begin
      $display("[particle_pool_integrator_core] OK");
    end else begin
      $display("[particle_pool_integrator_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ppi_pkg.sv
rtl/core/ppi_ctrl.sv
rtl/core/ppi_dp.sv
rtl/core/particle_pool_integrator_core.sv
tb/tb_top.sv
